// File: rtl/three_rotor_letter_cipher_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-rotor letter cipher
// Each macro expects clk and rst_n to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_LETTER_CIPHER_TOP_MACROS_SVH
`define THREE_ROTOR_LETTER_CIPHER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trlc_pkg.sv
// ----------------------------------------------------------------------------
// trlc_pkg
// Types, constants, rotor wiring tables and modulo-26 helpers for the cipher.
// ----------------------------------------------------------------------------
package trlc_pkg;

  localparam int unsigned Letters   = 26;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned REFL_LOW_W = 60;
  localparam int unsigned REFL_HIGH_W = 10;

  typedef logic [LETTER_W-1:0] letter_t;

  localparam letter_t FAST_START = 5'd10;

  typedef enum logic {
    OP_ENCIPHER = 1'b0,
    OP_RESTART  = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFL_LOW    = 3'd0,
    CFG_REFL_MID    = 3'd1,
    CFG_REFL_HIGH   = 3'd2,
    CFG_START_ONE   = 3'd3,
    CFG_START_TWO   = 3'd4,
    CFG_START_THREE = 3'd5
  } cfg_idx_t;

  // Current offsets of the three rotors.
  typedef struct packed {
    letter_t one;
    letter_t two;
    letter_t three;
  } rotor_pos_t;

  typedef letter_t rotor_tab_t [Letters];

  localparam rotor_tab_t WIRE_ONE = '{
    5'd4,  5'd10, 5'd12, 5'd5,  5'd11, 5'd6,  5'd3,  5'd16, 5'd21, 5'd25,
    5'd13, 5'd19, 5'd14, 5'd22, 5'd24, 5'd7,  5'd23, 5'd20, 5'd18, 5'd15,
    5'd0,  5'd8,  5'd1,  5'd17, 5'd2,  5'd9
  };

  localparam rotor_tab_t WIRE_TWO = '{
    5'd0,  5'd9,  5'd3,  5'd10, 5'd18, 5'd8,  5'd17, 5'd20, 5'd23, 5'd1,
    5'd11, 5'd7,  5'd22, 5'd19, 5'd12, 5'd2,  5'd16, 5'd6,  5'd25, 5'd13,
    5'd15, 5'd24, 5'd5,  5'd21, 5'd14, 5'd4
  };

  localparam rotor_tab_t WIRE_THREE = '{
    5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd2,  5'd15, 5'd17, 5'd19,
    5'd23, 5'd21, 5'd25, 5'd13, 5'd24, 5'd4,  5'd8,  5'd22, 5'd6,  5'd0,
    5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14
  };

  // Builds the reverse-direction table of a rotor at elaboration.
  function automatic rotor_tab_t invert_tab(rotor_tab_t w);
    rotor_tab_t inv;
    inv = '{default: '0};
    for (int i = 0; i < Letters; i++) begin
      inv[w[i]] = letter_t'(i);
    end
    return inv;
  endfunction

  localparam rotor_tab_t INV_ONE   = invert_tab(WIRE_ONE);
  localparam rotor_tab_t INV_TWO   = invert_tab(WIRE_TWO);
  localparam rotor_tab_t INV_THREE = invert_tab(WIRE_THREE);

  // Reduces any 5-bit code into 0..25.
  function automatic letter_t fold_letter(letter_t x);
    return (x >= letter_t'(Letters)) ? letter_t'(x - letter_t'(Letters)) : x;
  endfunction

  // (a + b) mod 26 for a, b in 0..25.
  function automatic letter_t add_mod(letter_t a, letter_t b);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(Letters)) begin
      s = s - (LETTER_W+1)'(Letters);
    end
    return s[LETTER_W-1:0];
  endfunction

  // (a - b) mod 26 for a, b in 0..25.
  function automatic letter_t sub_mod(letter_t a, letter_t b);
    logic [LETTER_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (LETTER_W+1)'(Letters) - {1'b0, b};
    end
    return s[LETTER_W-1:0];
  endfunction

endpackage

// File: rtl/trlc_if.sv
// ----------------------------------------------------------------------------
// trlc_in_if / trlc_out_if
// Valid/ready channels for plain letters in and cipher letters out.
// ----------------------------------------------------------------------------
interface trlc_in_if;
  import trlc_pkg::*;

  logic    valid;
  logic    ready;
  logic    opcode;
  letter_t plain_letter;

  modport source (output valid, output opcode, output plain_letter, input ready);
  modport sink   (input valid, input opcode, input plain_letter, output ready);
endinterface

interface trlc_out_if;
  import trlc_pkg::*;

  logic    valid;
  logic    ready;
  letter_t cipher_letter;

  modport source (output valid, output cipher_letter, input ready);
  modport sink   (input valid, input cipher_letter, output ready);
endinterface

// File: rtl/three_rotor_letter_cipher_top.sv
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher_top
// Three-rotor letter cipher with configurable reflector and restart opcode.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    opcode, plain_letter
//   out_chan  out  valid/ready    cipher_letter
//   cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
// One letter is accepted per cycle unless stalled; it passes s1, then out stage.
// Rotor offsets and carry counters update at accept, so back-to-back letters
// see the stepped rotors; the letter path is one pass of lookups per letter.
// A restart transaction updates state and yields no result.
// Reset is synchronous; clears config, valids, offsets and sets the fast count.
// With out_chan stalled, one more transaction is held in the input stage.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher_top (
  input  logic                              clk,
  input  logic                              rst_n,
  trlc_in_if.sink                           in_chan,
  trlc_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [trlc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [trlc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import trlc_pkg::*;

  `include "three_rotor_letter_cipher_top_macros.svh"

  // Configuration registers.
  logic [REFL_LOW_W-1:0]  refl_low_r;
  logic [REFL_LOW_W-1:0]  refl_mid_r;
  logic [REFL_HIGH_W-1:0] refl_high_r;
  letter_t                start_one_r;
  letter_t                start_two_r;
  letter_t                start_three_r;

  // Rotor state.
  rotor_pos_t pos_r;
  rotor_pos_t pos_nxt;
  letter_t    fast_cnt_r;
  letter_t    fast_cnt_nxt;
  letter_t    mid_cnt_r;
  letter_t    mid_cnt_nxt;
  letter_t    one_inc;

  // Input stage and result stage.
  logic       s1_vld_r;
  letter_t    s1_letter_r;
  rotor_pos_t s1_pos_r;
  logic       out_vld_r;
  letter_t    out_letter_r;
  letter_t    path_letter;

  logic in_fire;
  logic in_enc;
  logic in_restart;
  logic out_en;
  logic in_rdy;

  // Terms for the checks at the end.
  logic                                 enc_fire;
  logic                                 restart_fire;
  logic                                 cnt_home;
  logic                                 s1_stall;
  logic [$bits(rotor_pos_t)+LETTER_W:0] s1_word;

  assign out_en     = !out_vld_r || out_chan.ready;
  assign in_rdy     = !s1_vld_r || out_en;
  assign in_fire    = in_chan.valid && in_rdy;
  assign in_restart = (in_chan.opcode == OP_RESTART);
  assign in_enc     = !in_restart;
  assign one_inc    = add_mod(pos_r.one, letter_t'(1));

  assign in_chan.ready          = in_rdy;
  assign out_chan.valid         = out_vld_r;
  assign out_chan.cipher_letter = out_letter_r;

  assign enc_fire     = in_fire && in_enc;
  assign restart_fire = in_fire && in_restart;
  assign cnt_home     = (fast_cnt_r == FAST_START) && (mid_cnt_r == '0);
  assign s1_stall     = s1_vld_r && !out_en;
  assign s1_word      = {s1_vld_r, s1_letter_r, s1_pos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refl_low_r    <= '0;
      refl_mid_r    <= '0;
      refl_high_r   <= '0;
      start_one_r   <= '0;
      start_two_r   <= '0;
      start_three_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REFL_LOW:    refl_low_r    <= cfg_wdata[REFL_LOW_W-1:0];
        CFG_REFL_MID:    refl_mid_r    <= cfg_wdata[REFL_LOW_W-1:0];
        CFG_REFL_HIGH:   refl_high_r   <= cfg_wdata[REFL_HIGH_W-1:0];
        CFG_START_ONE:   start_one_r   <= cfg_wdata[LETTER_W-1:0];
        CFG_START_TWO:   start_two_r   <= cfg_wdata[LETTER_W-1:0];
        CFG_START_THREE: start_three_r <= cfg_wdata[LETTER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Rotor stepping and restart. A start letter outside 0..25 has no wiring
  // position, so that rotor keeps its offset.
  always_comb begin
    pos_nxt      = pos_r;
    fast_cnt_nxt = fast_cnt_r;
    mid_cnt_nxt  = mid_cnt_r;
    if (in_fire) begin
      if (in_restart) begin
        if (start_one_r < letter_t'(Letters)) begin
          pos_nxt.one = INV_ONE[start_one_r];
        end
        if (start_two_r < letter_t'(Letters)) begin
          pos_nxt.two = INV_TWO[start_two_r];
        end
        if (start_three_r < letter_t'(Letters)) begin
          pos_nxt.three = INV_THREE[start_three_r];
        end
        fast_cnt_nxt = FAST_START;
        mid_cnt_nxt  = '0;
      end else begin
        pos_nxt.one = one_inc;
        if (fast_cnt_r >= letter_t'(Letters - 1)) begin
          fast_cnt_nxt = '0;
          pos_nxt.two  = add_mod(pos_r.two, letter_t'(1));
          if (mid_cnt_r >= letter_t'(Letters - 1)) begin
            mid_cnt_nxt   = '0;
            pos_nxt.three = add_mod(pos_r.three, letter_t'(1));
          end else begin
            mid_cnt_nxt = mid_cnt_r + letter_t'(1);
          end
        end else begin
          fast_cnt_nxt = fast_cnt_r + letter_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      fast_cnt_r <= FAST_START;
      mid_cnt_r  <= '0;
    end else begin
      pos_r      <= pos_nxt;
      fast_cnt_r <= fast_cnt_nxt;
      mid_cnt_r  <= mid_cnt_nxt;
    end
  end

  // The input stage keeps the offsets that were current at accept.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_vld_r <= in_fire && in_enc;
      end
      if (out_en) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      s1_letter_r <= in_chan.plain_letter;
      s1_pos_r    <= pos_r;
    end
    if (out_en) begin
      out_letter_r <= path_letter;
    end
  end

  trlc_path u_path (
    .plain_letter  (s1_letter_r),
    .pos           (s1_pos_r),
    .refl_low      (refl_low_r),
    .refl_mid      (refl_mid_r),
    .refl_high     (refl_high_r),
    .cipher_letter (path_letter)
  );

  `TRLC_ASSERT_NEXT(a_restart_no_result, restart_fire, !s1_vld_r, "restart produced a result")
  `TRLC_ASSERT_NEXT(a_restart_counts, restart_fire, cnt_home, "restart did not restore counters")
  `TRLC_ASSERT_NEXT(a_rotor_one_step, enc_fire, pos_r.one == $past(one_inc), "rotor one stuck")
  `TRLC_ASSERT_NEXT(a_stage_hold, s1_stall, $stable(s1_word), "held transaction lost")

endmodule

// File: rtl/trlc_path.sv
// ----------------------------------------------------------------------------
// trlc_path
// Letter path: three rotors forward, reflector, three rotors back.
// ----------------------------------------------------------------------------
module trlc_path (
  input  trlc_pkg::letter_t                      plain_letter,
  input  trlc_pkg::rotor_pos_t                   pos,
  input  logic [trlc_pkg::REFL_LOW_W-1:0]        refl_low,
  input  logic [trlc_pkg::REFL_LOW_W-1:0]        refl_mid,
  input  logic [trlc_pkg::REFL_HIGH_W-1:0]       refl_high,
  output trlc_pkg::letter_t                      cipher_letter
);
  import trlc_pkg::*;

  localparam int unsigned REFL_ALL_W = 2 * REFL_LOW_W + REFL_HIGH_W;

  logic [REFL_ALL_W-1:0] refl_all;
  logic [7:0]            refl_idx;
  letter_t               p0;
  letter_t               f1;
  letter_t               f2;
  letter_t               f3;
  letter_t               refl_raw;
  letter_t               rf;
  letter_t               b3;
  letter_t               b2;

  assign refl_all = {refl_high, refl_mid, refl_low};

  always_comb begin
    p0       = fold_letter(plain_letter);
    f1       = WIRE_ONE[add_mod(p0, pos.one)];
    f2       = WIRE_TWO[add_mod(f1, pos.two)];
    f3       = WIRE_THREE[add_mod(f2, pos.three)];
    refl_idx = {3'b000, f3} * 8'd5;
    refl_raw = refl_all[refl_idx +: LETTER_W];
    rf       = fold_letter(refl_raw);
    b3       = sub_mod(INV_THREE[rf], pos.three);
    b2       = sub_mod(INV_TWO[b3], pos.two);
    cipher_letter = sub_mod(INV_ONE[b2], pos.one);
  end

endmodule
